>>> hw/rtl/fnvbi_pkg.sv
`timescale 1ns / 1ps
package fnvbi_pkg;

	localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
	localparam int          FNV_PRIME_SHIFT = 40;
	localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;

	localparam int          DIV_STEPS = 64;
	localparam int          DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int          CFG_IDX_W      = 2;
	localparam int          CFG_DATA_W     = 32;
	localparam logic [31:0] TABLE_SIZE_RST = 32'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGN_EXT   = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_START,
		ST_DIV
	} fnvbi_state_t;

	typedef struct packed {
		logic init;
		logic xor_en;
		logic mul_en;
	} hash_cmd_t;

endpackage

>>> hw/rtl/fnvbi_hash.sv
`timescale 1ns / 1ps
module fnvbi_hash import fnvbi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hash_cmd_t   cmd,
	input  logic [7:0]  key_byte,
	input  logic        sign_ext,
	output logic [63:0] hash
);

	logic [63:0] hash_q;
	logic [63:0] operand;
	logic [63:0] product;

	// prime = 2^40 + 0x1B3
	assign operand = (sign_ext && key_byte[7]) ? {56'hFF_FFFF_FFFF_FFFF, key_byte}
	                                           : {56'h0, key_byte};
	assign product = (hash_q << FNV_PRIME_SHIFT) + (hash_q * {55'h0, FNV_PRIME_LO});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (cmd.init) begin
			hash_q <= FNV_BASIS;
		end else if (cmd.xor_en) begin
			hash_q <= hash_q ^ operand;
		end else if (cmd.mul_en) begin
			hash_q <= product;
		end
	end

	assign hash = hash_q;

endmodule

>>> hw/rtl/fnvbi_mod.sv
`timescale 1ns / 1ps
module fnvbi_mod import fnvbi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] remainder
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [63:0]          dvd_q;
	logic [31:0]          dsr_q;
	logic [31:0]          rem_q;
	logic [32:0]          trial;
	logic [32:0]          diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[31:0];
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = (dsr_q == 32'd0) ? 32'd0 : rem_q;

endmodule

>>> hw/rtl/fnv1a_bucket_index.sv
`timescale 1ns / 1ps
// channel   dir  accept                   payload
// s_axis    in   s_axis_tvalid & tready   tdata: key_byte; tuser: no_byte; tlast: is_last
// m_axis    out  m_axis_tvalid & tready   tdata: hash_value, bucket_index
// cfg       in   cfg_we                   cfg_index 0 table_size, 1 sign_extend_bytes
//
// A key byte is accepted, then makes one pass through the constant
// multiplier. A last item adds a start step, the bit-serial remainder unit
// and a load step before the result is registered.
// Reset: running hash to the FNV offset basis, table_size 1024, sign extend off.
// A registered result waiting on m_axis_tready does not stop input; the next
// last item holds in the remainder state, with input not ready, until it drains.
module fnv1a_bucket_index import fnvbi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] key_byte
	input  logic                  s_axis_tuser,   // [0] no_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [95:0]           m_axis_tdata,   // [63:0] hash_value, [95:64] bucket_index
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	fnvbi_state_t state_q, state_d;
	hash_cmd_t    cmd;
	logic         last_q;
	logic         s_acc;
	logic         div_start;
	logic         div_busy;
	logic         out_free;
	logic         out_load;
	logic [63:0]  hash;
	logic [63:0]  key_hash_q;
	logic [31:0]  remainder;
	logic [31:0]  table_size_q;
	logic         sign_ext_q;
	logic         m_tvalid_q;
	logic [95:0]  m_tdata_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			sign_ext_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_SIZE: table_size_q <= cfg_data[31:0];
				REG_SIGN_EXT:   sign_ext_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				last_q <= s_axis_tlast;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (!s_axis_tuser) begin
						cmd.xor_en = 1'b1;
						state_d    = ST_MUL;
					end else if (s_axis_tlast) begin
						state_d = ST_START;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = last_q ? ST_START : ST_IDLE;
			end
			ST_START: begin
				cmd.init  = 1'b1;
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy && out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			key_hash_q <= hash;
		end
	end

	fnvbi_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.key_byte (s_axis_tdata),
		.sign_ext (sign_ext_q),
		.hash     (hash)
	);

	fnvbi_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hash),
		.divisor   (table_size_q),
		.busy      (div_busy),
		.remainder (remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {remainder, key_hash_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("remainder unit did not start");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> !div_busy)
		else $error("request accepted while remainder unit busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!div_busy && out_free))
		else $error("result loaded over pending result or unfinished remainder");

	a_mul_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_IDLE || state_q == ST_START))
		else $error("bad sequence after multiply");

endmodule
